// ===== design/rgb_luma_histogram_core_assert.svh =====
// assertion macros for the histogram core
// expects signals clk and arst_n in the module that uses them
`ifndef RGB_LUMA_HISTOGRAM_CORE_ASSERT_SVH
`define RGB_LUMA_HISTOGRAM_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define RLH_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define RLH_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rlh_pkg.sv =====
// shared types and constants of the rgb and luminance histogram core
// no dependencies
package rlh_pkg;

	localparam int COUNT_BITS    = 20;
	localparam int BIN_BITS      = 8;
	localparam int CHAN_BITS     = 2;
	localparam int ADDR_BITS     = CHAN_BITS + BIN_BITS;
	localparam int STORE_DEPTH   = 1 << ADDR_BITS;
	localparam int SIDE_BITS     = 14;
	localparam int POS_BITS      = 13;
	localparam int STEP_BITS     = 6;
	localparam int PHASE_BITS    = 5;
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [SIDE_BITS-1:0] MAX_SIDE   = 14'd8192;
	localparam logic [SIDE_BITS-1:0] SIDE_RESET = 14'd256;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [CHAN_BITS-1:0] CH_RED   = 2'd0;
	localparam logic [CHAN_BITS-1:0] CH_GREEN = 2'd1;
	localparam logic [CHAN_BITS-1:0] CH_BLUE  = 2'd2;
	localparam logic [CHAN_BITS-1:0] CH_LUMA  = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_READ
	} rlh_state_t;

	typedef struct packed {
		logic [SIDE_BITS-1:0] width;
		logic [SIDE_BITS-1:0] height;
	} rlh_geom_t;

	typedef struct packed {
		logic clear;
		logic advance;
	} rlh_pos_cmd_t;

endpackage

// ===== design/rgb_luma_histogram_core.sv =====
// top level of the rgb and luminance histogram core: sequencer and bin store
// depends on rlh_pkg, rlh_ram, rlh_cfg, rlh_raster and the assertion header
`include "rgb_luma_histogram_core_assert.svh"

// Usage
// An item is taken when start is high and busy is low. operation selects
// start (clear all bins and the raster position), pixel or bin read.
// A pixel that falls on the subsampling grid updates four bins (red, green,
// blue, luminance) by read-modify-write through the read and write ports
// of the bin store, one channel a cycle; busy stays high while it runs, so
// the next item waits for it. Pixels off the grid only move the raster
// position and leave busy low.
// A bin read keeps busy high one cycle; the item passes the read state and
// the registered read port of the store, then done is high for exactly one
// cycle with the result on bin_count. The receiver cannot stall, and the
// next item may be taken in the cycle done is high. A start clears the
// 1024 entries of the store one a cycle, with busy high until the pass ends;
// reset runs the same clearing pass, so the core is busy after its release.
// Frame sizes sit in two apb registers (width at 0, height at 4). The user
// must write them only while the core is idle; the core does not enforce it.
module rgb_luma_histogram_core import rlh_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               operation,
	input  logic [7:0]               red,
	input  logic [7:0]               green,
	input  logic [7:0]               blue,
	input  logic [CHAN_BITS-1:0]     read_channel,
	input  logic [BIN_BITS-1:0]      read_bin,
	output logic                     done,
	output logic [COUNT_BITS-1:0]    bin_count
);

	localparam logic [15:0] LUMA_R = 16'd13933;
	localparam logic [15:0] LUMA_G = 16'd46871;
	localparam logic [15:0] LUMA_B = 16'd4732;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	rlh_state_t state_q;
	rlh_state_t state_d;
	rlh_geom_t  geom;
	rlh_pos_cmd_t pos_cmd;

	logic                  accept;
	logic                  counted;
	logic [BIN_BITS-1:0]   r_q;
	logic [BIN_BITS-1:0]   g_q;
	logic [BIN_BITS-1:0]   b_q;
	logic [BIN_BITS-1:0]   lum_q;
	logic [23:0]           luma_sum;
	logic [CHAN_BITS-1:0]  ch_q;
	logic [ADDR_BITS-1:0]  rd_addr_q;
	logic [ADDR_BITS-1:0]  clr_q;
	logic [ADDR_BITS-1:0]  upd_addr;
	logic                  wr_valid_s1;
	logic [ADDR_BITS-1:0]  wr_addr_s1;
	logic                  done_q;

	logic                  mem_we;
	logic [ADDR_BITS-1:0]  mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [ADDR_BITS-1:0]  mem_raddr;
	logic [COUNT_BITS-1:0] mem_rdata;

	rlh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	rlh_raster u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.cmd     (pos_cmd),
		.counted (counted)
	);

	rlh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start & ~busy;
	assign done      = done_q;
	assign bin_count = mem_rdata;

	assign luma_sum = 24'(LUMA_R) * 24'(r_q) + 24'(LUMA_G) * 24'(g_q)
		+ 24'(LUMA_B) * 24'(b_q);

	always_comb begin
		case (ch_q)
			CH_RED:   upd_addr = {CH_RED, r_q};
			CH_GREEN: upd_addr = {CH_GREEN, g_q};
			CH_BLUE:  upd_addr = {CH_BLUE, b_q};
			default:  upd_addr = {CH_LUMA, lum_q};
		endcase
	end

	// write port: clearing pass, else the increment half of an update
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = wr_valid_s1;
			mem_waddr = wr_addr_s1;
			mem_wdata = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
		end
	end

	always_comb begin
		state_d         = state_q;
		pos_cmd.clear   = 1'b0;
		pos_cmd.advance = 1'b0;
		mem_re          = 1'b0;
		mem_raddr       = upd_addr;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_START: begin
							pos_cmd.clear = 1'b1;
							state_d       = ST_CLEAR;
						end
						OP_PIXEL: begin
							pos_cmd.advance = 1'b1;
							if (counted) begin
								state_d = ST_UPDATE;
							end
						end
						OP_READ: begin
							state_d = ST_READ;
						end
						default: ;
					endcase
				end
			end
			ST_UPDATE: begin
				mem_re = 1'b1;
				if (ch_q == CH_LUMA) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				mem_re    = 1'b1;
				mem_raddr = rd_addr_q;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ch_q        <= '0;
			wr_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			wr_valid_s1 <= (state_q == ST_UPDATE);
			done_q      <= (state_q == ST_READ);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_BITS'(1);
			end else if (pos_cmd.clear) begin
				clr_q <= '0;
			end
			if (state_q == ST_UPDATE) begin
				ch_q <= ch_q + CHAN_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= upd_addr;
		lum_q      <= luma_sum[23:16];
		if (accept && operation == OP_PIXEL) begin
			r_q <= red;
			g_q <= green;
			b_q <= blue;
		end
		if (accept && operation == OP_READ) begin
			rd_addr_q <= {read_channel, read_bin};
		end
	end

	`RLH_ASSERT_NEXT(a_read_gives_done, state_q == ST_READ, done_q, "bin read gave no result")
	`RLH_ASSERT_SAME(a_no_update_in_clear, wr_valid_s1, state_q != ST_CLEAR, "update during clear")
	`RLH_ASSERT_SAME(a_no_raw_overlap, (state_q == ST_UPDATE) && wr_valid_s1, upd_addr != wr_addr_s1, "read of a bin being written")
	`RLH_ASSERT_NEXT(a_clear_ends, (state_q == ST_CLEAR) && (clr_q == '1), state_q == ST_IDLE, "clearing pass overran")

endmodule

// ===== design/rlh_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rlh_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024,
	localparam int ABITS = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ABITS-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [ABITS-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/rlh_cfg.sv =====
// frame size registers behind the apb port, with clamping of the sizes
// depends on rlh_pkg
module rlh_cfg import rlh_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output rlh_geom_t                geom
);

	logic [SIDE_BITS-1:0] width_q;
	logic [SIDE_BITS-1:0] height_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_RESET;
			height_q <= SIDE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[SIDE_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[SIDE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = CFG_DATA_BITS'(width_q);
			REG_HEIGHT: prdata = CFG_DATA_BITS'(height_q);
			default:    prdata = '0;
		endcase
	end

	// zero is passed on as one, anything above the maximum side as the maximum
	always_comb begin
		if (width_q == '0) begin
			geom.width = SIDE_BITS'(1);
		end else if (width_q > MAX_SIDE) begin
			geom.width = MAX_SIDE;
		end else begin
			geom.width = width_q;
		end
		if (height_q == '0) begin
			geom.height = SIDE_BITS'(1);
		end else if (height_q > MAX_SIDE) begin
			geom.height = MAX_SIDE;
		end else begin
			geom.height = height_q;
		end
	end

endmodule

// ===== design/rlh_raster.sv =====
// raster position and subsampling phase counters
// depends on rlh_pkg
module rlh_raster import rlh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  rlh_geom_t    geom,
	input  rlh_pos_cmd_t cmd,
	output logic         counted
);

	logic [POS_BITS-1:0]   col_q;
	logic [POS_BITS-1:0]   row_q;
	logic [PHASE_BITS-1:0] col_ph_q;
	logic [PHASE_BITS-1:0] row_ph_q;
	logic [STEP_BITS-1:0]  step_w;
	logic [STEP_BITS-1:0]  step_h;
	logic [STEP_BITS-1:0]  step;
	logic [SIDE_BITS-1:0]  col_inc;
	logic [SIDE_BITS-1:0]  row_inc;
	logic [STEP_BITS-1:0]  col_ph_inc;
	logic [STEP_BITS-1:0]  row_ph_inc;

	assign step_w = geom.width[SIDE_BITS-1:BIN_BITS];
	assign step_h = geom.height[SIDE_BITS-1:BIN_BITS];

	always_comb begin
		step = (step_w > step_h) ? step_w : step_h;
		if (step == '0) begin
			step = STEP_BITS'(1);
		end
	end

	assign col_inc    = {1'b0, col_q} + SIDE_BITS'(1);
	assign row_inc    = {1'b0, row_q} + SIDE_BITS'(1);
	assign col_ph_inc = {1'b0, col_ph_q} + STEP_BITS'(1);
	assign row_ph_inc = {1'b0, row_ph_q} + STEP_BITS'(1);
	assign counted    = (col_ph_q == '0) && (row_ph_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			col_ph_q <= '0;
			row_ph_q <= '0;
		end else if (cmd.clear) begin
			col_q    <= '0;
			row_q    <= '0;
			col_ph_q <= '0;
			row_ph_q <= '0;
		end else if (cmd.advance) begin
			if (col_inc >= geom.width) begin
				col_q    <= '0;
				col_ph_q <= '0;
				if (row_inc >= geom.height) begin
					row_q    <= '0;
					row_ph_q <= '0;
				end else begin
					row_q    <= row_inc[POS_BITS-1:0];
					row_ph_q <= (row_ph_inc >= step) ? '0 : row_ph_inc[PHASE_BITS-1:0];
				end
			end else begin
				col_q    <= col_inc[POS_BITS-1:0];
				col_ph_q <= (col_ph_inc >= step) ? '0 : col_ph_inc[PHASE_BITS-1:0];
			end
		end
	end

endmodule
